FILE: hw/rtl/utf8d_pkg.sv
`timescale 1ns / 1ps

package utf8d_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_BAD_CONT = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  localparam int unsigned CP_BITS    = 21;
  localparam int unsigned CNT_OUT_BITS = 16;

  // Lead and continuation byte patterns
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;
  localparam logic [7:0] PAY_CONT   = 8'h3F;
  localparam logic [7:0] PAY_LEAD2  = 8'h1F;
  localparam logic [7:0] PAY_LEAD3  = 8'h0F;
  localparam logic [7:0] PAY_LEAD4  = 8'h07;

  // Decoder state apart from the point counter
  typedef struct packed {
    logic [1:0]         pending;
    logic [CP_BITS-1:0] partial;
    logic               discarding;
  } dec_state_t;

  // One result item apart from the count
  typedef struct packed {
    logic [CP_BITS-1:0] code_point;
    status_t            status;
    logic               buffer_end;
  } dec_result_t;

endpackage

FILE: hw/rtl/utf8_stream_decoder.sv
`timescale 1ns / 1ps

// Streaming UTF-8 decoder. Takes one byte per item (tlast on the buffer's
// final byte) and returns one result for each completed code point or error:
// code point and running count in tdata, status in tuser, buffer end in tlast.
// One byte is accepted every cycle unless the result register stalls; a byte
// passes the input register and the decode step into the result register.
// Throughput is set only by the downstream tready, which stalls the input
// register when the result register is full.
// After an error, bytes up to the buffer's last byte produce no result.
module utf8_stream_decoder import utf8d_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [20:0] code_point, [36:21] count, [39:37] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // buffer_end
);

  logic                  in_valid_r;
  logic [7:0]            in_byte_r;
  logic                  in_last_r;
  dec_state_t            state_r;
  logic [COUNT_BITS-1:0] points_r;
  dec_state_t            state_nxt;
  logic [COUNT_BITS-1:0] points_nxt;
  logic                  emit;
  dec_result_t           result;
  logic [COUNT_BITS-1:0] result_count;
  logic                  out_valid_r;
  dec_result_t           out_res_r;
  logic [CNT_OUT_BITS-1:0] out_count_r;
  logic                  out_free;
  logic                  advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  utf8d_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .cur_state    (state_r),
    .cur_points   (points_r),
    .byte_value   (in_byte_r),
    .last_byte    (in_last_r),
    .nxt_state    (state_nxt),
    .nxt_points   (points_nxt),
    .emit         (emit),
    .result       (result),
    .result_count (result_count)
  );

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Advance decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= '0;
      points_r <= '0;
    end else if (advance) begin
      state_r  <= state_nxt;
      points_r <= points_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && emit;
    end
    if (advance && emit) begin
      out_res_r   <= result;
      out_count_r <= CNT_OUT_BITS'(result_count);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_count_r, out_res_r.code_point};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.buffer_end;

endmodule

FILE: hw/rtl/utf8d_step.sv
`timescale 1ns / 1ps

module utf8d_step import utf8d_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  dec_state_t              cur_state,
  input  logic [COUNT_BITS-1:0]   cur_points,
  input  logic [7:0]              byte_value,
  input  logic                    last_byte,
  output dec_state_t              nxt_state,
  output logic [COUNT_BITS-1:0]   nxt_points,
  output logic                    emit,
  output dec_result_t             result,
  output logic [COUNT_BITS-1:0]   result_count
);

  logic               do_complete;
  logic               do_fail;
  status_t            fail_code;
  logic [CP_BITS-1:0] cp_val;
  logic [CP_BITS-1:0] lead_val;
  logic [1:0]         lead_need;
  logic [CP_BITS-1:0] shifted;
  logic [1:0]         pend_dec;
  logic [COUNT_BITS-1:0] pts_inc;

  assign shifted  = {cur_state.partial[CP_BITS-7:0], byte_value[5:0] & PAY_CONT[5:0]};
  assign pend_dec = cur_state.pending - 2'd1;
  assign pts_inc  = (cur_points == {COUNT_BITS{1'b1}}) ? cur_points
                                                       : cur_points + COUNT_BITS'(1);

  // Classify the byte against the current state
  always_comb begin
    do_complete = 1'b0;
    do_fail     = 1'b0;
    fail_code   = ST_OK;
    cp_val      = '0;
    lead_val    = '0;
    lead_need   = 2'd0;
    nxt_state   = cur_state;
    nxt_points  = cur_points;

    if (cur_state.discarding) begin
      if (last_byte) begin
        nxt_state  = '0;
        nxt_points = '0;
      end
    end else if (cur_state.pending == 2'd0) begin
      priority if (!byte_value[7]) begin
        do_complete = 1'b1;
        cp_val      = CP_BITS'(byte_value);
      end else if ((byte_value & LEAD2_MASK) == LEAD2_TAG) begin
        lead_need = 2'd1;
        lead_val  = CP_BITS'(byte_value & PAY_LEAD2);
      end else if ((byte_value & LEAD3_MASK) == LEAD3_TAG) begin
        lead_need = 2'd2;
        lead_val  = CP_BITS'(byte_value & PAY_LEAD3);
      end else if ((byte_value & LEAD4_MASK) == LEAD4_TAG) begin
        lead_need = 2'd3;
        lead_val  = CP_BITS'(byte_value & PAY_LEAD4);
      end else begin
        do_fail   = 1'b1;
        fail_code = ST_BAD_LEAD;
      end
      // A lead byte that closes the buffer leaves the point truncated
      if (lead_need != 2'd0) begin
        if (last_byte) begin
          do_fail   = 1'b1;
          fail_code = ST_TRUNC;
        end else begin
          nxt_state.pending = lead_need;
          nxt_state.partial = lead_val;
        end
      end
    end else if ((byte_value & CONT_MASK) != CONT_TAG) begin
      do_fail   = 1'b1;
      fail_code = ST_BAD_CONT;
    end else if (pend_dec == 2'd0) begin
      do_complete = 1'b1;
      cp_val      = shifted;
    end else if (last_byte) begin
      do_fail   = 1'b1;
      fail_code = ST_TRUNC;
    end else begin
      nxt_state.pending = pend_dec;
      nxt_state.partial = shifted;
    end

    // Finish the point or drop into discard; buffer end clears everything
    if (do_complete) begin
      nxt_state.pending = 2'd0;
      nxt_state.partial = '0;
      nxt_points        = last_byte ? '0 : pts_inc;
    end else if (do_fail) begin
      nxt_state.pending    = 2'd0;
      nxt_state.partial    = '0;
      nxt_state.discarding = !last_byte;
      if (last_byte) begin
        nxt_points = '0;
      end
    end
  end

  // Build the result item
  assign emit              = do_complete | do_fail;
  assign result.code_point = do_complete ? cp_val : '0;
  assign result.status     = do_complete ? ST_OK : fail_code;
  assign result.buffer_end = last_byte;
  assign result_count      = do_complete ? pts_inc : cur_points;

endmodule
